@@ rtl/core/assert_macros.svh @@
// Assertion helpers for the checker file skl_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define SKL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define SKL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/skl_pkg.sv @@
package skl_pkg;

    // operation codes
    localparam logic [2:0] KIND_INSERT  = 3'd0;
    localparam logic [2:0] KIND_DELETE  = 3'd1;
    localparam logic [2:0] KIND_SEARCH  = 3'd2;
    localparam logic [2:0] KIND_LIST_UP = 3'd3;
    localparam logic [2:0] KIND_LIST_DN = 3'd4;

    // result status codes
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_DUP   = 3'd1;
    localparam logic [2:0] ST_MISS  = 3'd2;
    localparam logic [2:0] ST_FULL  = 3'd3;
    localparam logic [2:0] ST_EMPTY = 3'd4;

    // compare unit result
    typedef struct packed {
        logic ge;
        logic eq;
    } t_cmp;

endpackage

@@ rtl/core/skl_ram.sv @@
module skl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/skl_cmp.sv @@
module skl_cmp #(
    parameter int KEY_BITS = 16
) (
    input  logic [KEY_BITS-1:0] i_a,
    input  logic [KEY_BITS-1:0] i_b,
    output skl_pkg::t_cmp       o_res
);

    // unsigned magnitude compare of a stored key against the probe key
    assign o_res.ge = (i_a >= i_b);
    assign o_res.eq = (i_a == i_b);

endmodule

@@ rtl/core/sorted_key_list_core.sv @@
// Steps: insert/delete/search compare one entry at a time (at least one), then move
//   the entries behind the position one by one, and an insert then places its key.
//   Listing: one key per cycle; an empty list gives a single ST_EMPTY result.
// Throughput: one transaction at a time; the next is taken at the edge of the last result.
//   Results cannot be stalled.
// Reset (synchronous, active low) empties the list; key memory contents are not cleared.
module sorted_key_list_core #(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_kind,
    input  logic [15:0] i_key,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [15:0] o_out_key,
    output logic        o_last
);

    // IW indexes the key memory, CW also holds the count itself
    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    // S_SCAN : walk the list to find the first key not below the probe
    // S_UP   : move entries one slot up to open a hole (insert)
    // S_PUT  : drop the new key into the hole
    // S_DN   : move entries one slot down over the removed key (delete)
    // S_LIST : stream the stored keys out, one per cycle
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_UP,
        S_PUT,
        S_DN,
        S_LIST
    } t_state;

    t_state r_state, n_state;
    logic [2:0]          r_kind, n_kind;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_ptr, n_ptr;     // index of the entry whose read data is present
    logic [CW-1:0]       r_pos, n_pos;     // insert/delete position
    logic [CW-1:0]       r_left, n_left;   // keys still to list
    logic                r_valid, n_valid;
    logic [2:0]          r_status, n_status;
    logic [KEY_BITS-1:0] r_okey, n_okey;
    logic                r_last, n_last;

    // memory port and compare unit hookup
    logic                w_we;
    logic [IW-1:0]       w_wr_addr;
    logic [KEY_BITS-1:0] w_wr_data;
    logic [IW-1:0]       w_rd_addr;
    logic [KEY_BITS-1:0] w_rd_data;
    skl_pkg::t_cmp       w_cmp;

    logic [31:0]         w_key32;
    logic [31:0]         w_okey32;
    logic [KEY_BITS-1:0] w_in_key;
    logic [CW-1:0]       w_cnt_m1;
    logic [CW-1:0]       w_ptr_p1;
    logic [CW-1:0]       w_ptr_m1;
    logic [CW-1:0]       w_pos;
    logic                w_hit;
    logic                w_scan_end;

    skl_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    skl_cmp #(
        .KEY_BITS (KEY_BITS)
    ) u_cmp (
        .i_a   (w_rd_data),
        .i_b   (r_key),
        .o_res (w_cmp)
    );

    // incoming key is trimmed (or zero-extended) to the stored key width
    assign w_key32  = {16'd0, i_key};
    assign w_in_key = w_key32[KEY_BITS-1:0];

    assign w_cnt_m1 = r_count - ONE_C;
    assign w_ptr_p1 = r_ptr + ONE_C;
    assign w_ptr_m1 = r_ptr - ONE_C;

    // scan stops at the first entry >= key, or at the last stored entry, or at once on an empty list
    assign w_scan_end = (r_count == '0) || w_cmp.ge || (r_ptr == w_cnt_m1);
    assign w_hit      = (r_count != '0) && w_cmp.ge && w_cmp.eq;
    assign w_pos      = ((r_count != '0) && w_cmp.ge) ? r_ptr : r_count;

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_key     = r_key;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_pos     = r_pos;
        n_left    = r_left;
        n_valid   = 1'b0;
        n_status  = r_status;
        n_okey    = r_okey;
        n_last    = r_last;
        w_we      = 1'b0;
        w_wr_addr = r_pos[IW-1:0];
        w_wr_data = r_key;
        w_rd_addr = w_ptr_p1[IW-1:0];

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_kind = i_kind;
                    n_key  = w_in_key;
                    case (i_kind)
                        skl_pkg::KIND_INSERT, skl_pkg::KIND_DELETE,
                        skl_pkg::KIND_SEARCH: begin
                            n_ptr     = '0;
                            w_rd_addr = '0;
                            n_state   = S_SCAN;
                        end
                        skl_pkg::KIND_LIST_UP: begin
                            n_ptr     = '0;
                            n_left    = r_count;
                            w_rd_addr = '0;
                            n_state   = S_LIST;
                        end
                        skl_pkg::KIND_LIST_DN: begin
                            n_ptr     = w_cnt_m1;
                            n_left    = r_count;
                            w_rd_addr = w_cnt_m1[IW-1:0];
                            n_state   = S_LIST;
                        end
                        default: begin
                            n_state = S_IDLE;   // unused codes are dropped
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (!w_scan_end) begin
                    n_ptr     = w_ptr_p1;
                    w_rd_addr = w_ptr_p1[IW-1:0];
                end else begin
                    n_pos  = w_pos;
                    n_okey = r_key;
                    n_last = 1'b1;
                    n_state = S_IDLE;
                    case (r_kind)
                        skl_pkg::KIND_INSERT: begin
                            // duplicate wins over full
                            if (w_hit) begin
                                n_valid  = 1'b1;
                                n_status = skl_pkg::ST_DUP;
                            end else if (r_count >= CAP_C) begin
                                n_valid  = 1'b1;
                                n_status = skl_pkg::ST_FULL;
                            end else if (w_pos == r_count) begin
                                n_state = S_PUT;
                            end else begin
                                n_ptr     = w_cnt_m1;
                                w_rd_addr = w_cnt_m1[IW-1:0];
                                n_state   = S_UP;
                            end
                        end
                        skl_pkg::KIND_DELETE: begin
                            if (!w_hit) begin
                                n_valid  = 1'b1;
                                n_status = skl_pkg::ST_MISS;
                            end else if (w_pos == w_cnt_m1) begin
                                // removing the tail: nothing to move
                                n_valid  = 1'b1;
                                n_status = skl_pkg::ST_OK;
                                n_count  = w_cnt_m1;
                            end else begin
                                n_ptr     = w_pos + ONE_C;
                                w_rd_addr = w_ptr_p1[IW-1:0];
                                n_state   = S_DN;
                            end
                        end
                        default: begin
                            // search
                            n_valid  = 1'b1;
                            n_status = w_hit ? skl_pkg::ST_OK : skl_pkg::ST_MISS;
                        end
                    endcase
                end
            end

            S_UP: begin
                w_we      = 1'b1;
                w_wr_addr = w_ptr_p1[IW-1:0];
                w_wr_data = w_rd_data;
                if (r_ptr == r_pos) begin
                    n_state = S_PUT;
                end else begin
                    n_ptr     = w_ptr_m1;
                    w_rd_addr = w_ptr_m1[IW-1:0];
                end
            end

            S_PUT: begin
                w_we      = 1'b1;
                w_wr_addr = r_pos[IW-1:0];
                w_wr_data = r_key;
                n_count   = r_count + ONE_C;
                n_valid   = 1'b1;
                n_status  = skl_pkg::ST_OK;
                n_okey    = r_key;
                n_last    = 1'b1;
                n_state   = S_IDLE;
            end

            S_DN: begin
                w_we      = 1'b1;
                w_wr_addr = w_ptr_m1[IW-1:0];
                w_wr_data = w_rd_data;
                if (r_ptr == w_cnt_m1) begin
                    n_count  = w_cnt_m1;
                    n_valid  = 1'b1;
                    n_status = skl_pkg::ST_OK;
                    n_okey   = r_key;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_ptr     = w_ptr_p1;
                    w_rd_addr = w_ptr_p1[IW-1:0];
                end
            end

            S_LIST: begin
                n_valid = 1'b1;
                if (r_left == '0) begin
                    n_status = skl_pkg::ST_EMPTY;
                    n_okey   = '0;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_status = skl_pkg::ST_OK;
                    n_okey   = w_rd_data;
                    n_last   = (r_left == ONE_C);
                    n_left   = r_left - ONE_C;
                    if (r_left == ONE_C) begin
                        n_state = S_IDLE;
                    end else if (r_kind == skl_pkg::KIND_LIST_UP) begin
                        n_ptr     = w_ptr_p1;
                        w_rd_addr = w_ptr_p1[IW-1:0];
                    end else begin
                        n_ptr     = w_ptr_m1;
                        w_rd_addr = w_ptr_m1[IW-1:0];
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
        r_kind   <= n_kind;
        r_key    <= n_key;
        r_ptr    <= n_ptr;
        r_pos    <= n_pos;
        r_left   <= n_left;
        r_status <= n_status;
        r_okey   <= n_okey;
        r_last   <= n_last;
    end

    assign w_okey32  = 32'(r_okey);
    assign busy      = (r_state != S_IDLE);
    assign o_valid   = r_valid;
    assign o_status  = r_status;
    assign o_out_key = w_okey32[15:0];
    assign o_last    = r_last;

endmodule

@@ rtl/core/skl_chk.sv @@
`include "assert_macros.svh"

module skl_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [2:0]  i_kind,
    input logic        o_valid,
    input logic        o_last
);

    logic w_take;
    logic w_known;

    assign w_take  = start && !busy;
    assign w_known = (i_kind <= skl_pkg::KIND_LIST_DN);

    // the final result of a transaction frees the block
    `SKL_ASSERT(a_last_frees, i_clk, i_rst_n, o_valid && o_last |-> !busy, "busy after last result")

    // a listing streams without gaps until its last key
    `SKL_ASSERT(a_list_stream, i_clk, i_rst_n, o_valid && !o_last |-> busy ##1 o_valid, "gap in listing")

    // known operations occupy the block and never answer in the accept cycle
    `SKL_ASSERT(a_known_busy, i_clk, i_rst_n, w_take && w_known |=> busy && !o_valid, "known op not taken")

    // unused operation codes are dropped silently
    `SKL_ASSERT(a_unused_drop, i_clk, i_rst_n, w_take && !w_known |=> !busy && !o_valid, "unused op acted on")

    `SKL_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !busy && !o_valid, "not idle after reset")

endmodule

bind sorted_key_list_core skl_chk u_skl_chk (.*);

@@ sim/skl_checker.sv @@
`timescale 1ns / 1ps

// Watches both sides of sorted_key_list_core, keeps its own copy of the key list and
// checks every result strobe against the oldest outstanding prediction.
module skl_checker #(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [2:0]  i_kind,
    input  logic [15:0] i_key,
    input  logic        i_valid,
    input  logic [2:0]  i_status,
    input  logic [15:0] i_out_key,
    input  logic        i_last,
    output int          o_mismatches,
    output int          o_pending,
    output int          o_checked
);

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] key;
        logic        last;
    } t_list_result;

    t_list_result expected_results[$];
    t_list_result want;
    logic [15:0]  held_keys [CAPACITY];
    int           held_count     = 0;
    int           mismatch_count = 0;
    int           checked_count  = 0;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic push_result(input logic [2:0] status, input logic [15:0] key,
                               input logic last);
        t_list_result r;
        r.status = status;
        r.key    = key;
        r.last   = last;
        expected_results.push_back(r);
    endtask

    // apply one accepted transaction to the shadow list, queue what it should emit
    task automatic predict_transaction(input logic [2:0] op, input logic [15:0] op_key);
        int   pos;
        logic hit;
        pos = 0;
        while (pos < held_count && held_keys[pos] < op_key) pos++;
        hit = (pos < held_count) && (held_keys[pos] == op_key);
        case (op)
            skl_pkg::KIND_INSERT: begin
                if (hit) begin
                    push_result(skl_pkg::ST_DUP, op_key, 1'b1);
                end else if (held_count >= CAPACITY) begin
                    push_result(skl_pkg::ST_FULL, op_key, 1'b1);
                end else begin
                    for (int i = held_count; i > pos; i--) held_keys[i] = held_keys[i - 1];
                    held_keys[pos] = op_key;
                    held_count++;
                    push_result(skl_pkg::ST_OK, op_key, 1'b1);
                end
            end
            skl_pkg::KIND_DELETE, skl_pkg::KIND_SEARCH: begin
                if (!hit) begin
                    push_result(skl_pkg::ST_MISS, op_key, 1'b1);
                end else begin
                    if (op == skl_pkg::KIND_DELETE) begin
                        for (int i = pos; i + 1 < held_count; i++)
                            held_keys[i] = held_keys[i + 1];
                        held_count--;
                    end
                    push_result(skl_pkg::ST_OK, op_key, 1'b1);
                end
            end
            skl_pkg::KIND_LIST_UP, skl_pkg::KIND_LIST_DN: begin
                if (held_count == 0) begin
                    push_result(skl_pkg::ST_EMPTY, 16'h0000, 1'b1);
                end else begin
                    for (int i = 0; i < held_count; i++)
                        push_result(skl_pkg::ST_OK,
                                    (op == skl_pkg::KIND_LIST_UP) ? held_keys[i]
                                        : held_keys[held_count - 1 - i],
                                    i == held_count - 1);
                end
            end
            default: ;  // unused codes: no result, list untouched
        endcase
    endtask

    // results first: a last strobe may share an edge with the next acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_count = 0;
            expected_results.delete();
        end else begin
            if (i_valid) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result status %0d key %h last %b",
                                              i_status, i_out_key, i_last));
                end else begin
                    want = expected_results.pop_front();
                    checked_count++;
                    if (i_status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d (key %h)",
                                                  i_status, want.status, want.key));
                    if (i_out_key !== want.key)
                        report_mismatch($sformatf("out_key %h, want %h", i_out_key, want.key));
                    if (i_last !== want.last)
                        report_mismatch($sformatf("last %b, want %b (key %h)",
                                                  i_last, want.last, want.key));
                end
            end
            if (i_start && !i_busy) predict_transaction(i_kind, i_key);
        end
        o_pending    <= expected_results.size();
        o_mismatches <= mismatch_count;
        o_checked    <= checked_count;
    end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

// Stimulus and verdict for sorted_key_list_core. All prediction and comparison
// lives in skl_checker; this module only issues transactions and watches progress.
module tb_top;

    localparam int  CAPACITY       = 16;
    localparam real HALF_PERIOD    = 6.0;
    localparam int  RESET_CYCLES   = 6;
    localparam int  SETTLE_CYCLES  = 2 * CAPACITY + 8;
    localparam int  MAX_GAP        = 30;
    // covers the longest legal quiet stretch (a transaction, a sender gap or the settle pause), with margin
    localparam int  WATCHDOG_LIMIT = 1000;
    localparam int  PHASE_ITEMS    = 100;
    localparam int  POOL_SIZE      = 24;

    // codes the block must ignore
    localparam logic [2:0] KIND_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] KIND_LAST_UNUSED  = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  kind;
    logic [15:0] key;
    logic        res_valid;
    logic [2:0]  res_status;
    logic [15:0] res_key;
    logic        res_last;

    int          mismatches;
    int          pending;
    int          checked;
    int          idle_cycles = 0;
    int          sent_by_kind [8];
    logic [15:0] key_pool [POOL_SIZE];

    always #(HALF_PERIOD) i_clk = ~i_clk;

    sorted_key_list_core #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (16)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_kind    (kind),
        .i_key     (key),
        .o_valid   (res_valid),
        .o_status  (res_status),
        .o_out_key (res_key),
        .o_last    (res_last)
    );

    skl_checker #(
        .CAPACITY (CAPACITY)
    ) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_kind       (kind),
        .i_key        (key),
        .i_valid      (res_valid),
        .i_status     (res_status),
        .i_out_key    (res_key),
        .i_last       (res_last),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Watchdog: any accepted transaction or result strobe counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || res_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no progress for %0d cycles, %0d results outstanding",
                     idle_cycles, pending);
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Issue one transaction and hold it until the block takes it. With idle_pct > 0 the
    // sender then goes quiet for a random gap, scrambling kind/key so the block must
    // ignore them while start is low. With no gap, start simply stays high.
    task automatic send_op(input logic [2:0] op, input logic [15:0] op_key,
                           input int idle_pct);
        int gap;
        start <= 1'b1;
        kind  <= op;
        key   <= op_key;
        do @(posedge i_clk); while (busy);
        sent_by_kind[op]++;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            kind  <= 3'($urandom);
            key   <= 16'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Sender holds off until every predicted result is back, then lets the block
    // finish anything that produces no result (unused codes) before moving on.
    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Random mix: keys mostly from a small pool so hits, duplicates and a full list
    // are common; the rest span the whole key range. Insert/delete weights steer the
    // fill level so each phase spends time near empty or near full.
    task automatic run_phase(input int idle_pct, input int ins_w, input int del_w);
        int          counted;
        int          r;
        logic [2:0]  op;
        logic [15:0] op_key;
        counted = 0;
        while (counted < PHASE_ITEMS) begin
            r = $urandom_range(99);
            if (r < 4)
                op = KIND_FIRST_UNUSED + 3'($urandom_range(2));
            else if (r < 4 + ins_w)
                op = skl_pkg::KIND_INSERT;
            else if (r < 4 + ins_w + del_w)
                op = skl_pkg::KIND_DELETE;
            else if (r < 24 + ins_w + del_w)
                op = skl_pkg::KIND_SEARCH;
            else
                op = $urandom_range(1) ? skl_pkg::KIND_LIST_UP : skl_pkg::KIND_LIST_DN;
            if ($urandom_range(9) < 7)
                op_key = key_pool[$urandom_range(POOL_SIZE - 1)];
            else
                op_key = 16'($urandom);
            send_op(op, op_key, idle_pct);
            if (op < KIND_FIRST_UNUSED) counted++;
        end
        settle();
    endtask

    initial begin
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        kind    <= skl_pkg::KIND_INSERT;
        key     <= 16'h0000;
        foreach (sent_by_kind[i]) sent_by_kind[i] = 0;
        foreach (key_pool[i]) key_pool[i] = 16'($urandom);
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed: empty list, key extremes, fill to capacity, corner rejects ---
        send_op(skl_pkg::KIND_LIST_UP, 16'h0000, 0);    // empty list, ascending
        send_op(skl_pkg::KIND_LIST_DN, 16'hFFFF, 0);    // empty list, descending
        send_op(skl_pkg::KIND_DELETE,  16'h1234, 0);    // miss on empty list
        send_op(skl_pkg::KIND_INSERT,  16'h0000, 0);
        send_op(skl_pkg::KIND_INSERT,  16'hFFFF, 0);
        send_op(skl_pkg::KIND_INSERT,  16'h8000, 0);
        // 13 distinct keys in scrambled order, forcing shifts in the middle
        for (int i = 0; i < 13; i++)
            send_op(skl_pkg::KIND_INSERT, 16'(16'h1000 + ((i * 7) % 13) * 16'h0ABC), 0);
        send_op(skl_pkg::KIND_INSERT,  16'hFFFF, 0);    // duplicate wins over full
        send_op(skl_pkg::KIND_INSERT,  16'h0001, 0);    // full
        send_op(skl_pkg::KIND_SEARCH,  16'h8000, 0);    // hit
        send_op(skl_pkg::KIND_SEARCH,  16'h0002, 0);    // miss
        send_op(skl_pkg::KIND_LIST_UP, 16'h5A5A, 0);    // full-length stream
        send_op(skl_pkg::KIND_LIST_DN, 16'hA5A5, 0);
        send_op(skl_pkg::KIND_DELETE,  16'h0000, 0);    // head
        send_op(skl_pkg::KIND_DELETE,  16'hFFFF, 0);    // tail
        send_op(KIND_FIRST_UNUSED, 16'h8000, 0);        // ignored codes
        send_op(KIND_LAST_UNUSED,  16'h7FFF, 0);
        settle();

        // --- random phases: sender idle mix and fill bias vary ---
        run_phase(0,  35, 25);
        run_phase(67, 50, 15);
        run_phase(26, 20, 45);
        run_phase(0,  35, 25);

        $display("covered %0d inserts, %0d deletes, %0d searches, %0d listings, %0d unused codes",
                 sent_by_kind[skl_pkg::KIND_INSERT], sent_by_kind[skl_pkg::KIND_DELETE],
                 sent_by_kind[skl_pkg::KIND_SEARCH],
                 sent_by_kind[skl_pkg::KIND_LIST_UP] + sent_by_kind[skl_pkg::KIND_LIST_DN],
                 sent_by_kind[KIND_FIRST_UNUSED] + sent_by_kind[KIND_FIRST_UNUSED + 3'd1]
                     + sent_by_kind[KIND_LAST_UNUSED]);
        $display("%0d results checked over four idle mixes, %0d mismatches, %0d left over",
                 checked, mismatches, pending);
        if (mismatches == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
